[design/kcc_pkg.sv]
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants of the keypad calculator controller: key kinds,
// pending operator codes, shared arithmetic unit functions and state machines.
// ----------------------------------------------------------------------------
package kcc_pkg;

  localparam int KIND_W = 3;
  localparam int CODE_W = 4;
  localparam int VAL_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KEY_DIGIT  = 3'd0,
    KEY_OPER   = 3'd1,
    KEY_EQUALS = 3'd2,
    KEY_DELETE = 3'd3,
    KEY_CLEAR  = 3'd4
  } key_kind_e;

  // Highest valid operator key code (power)
  localparam logic [CODE_W-1:0] OPER_CODE_MAX = 4'd4;

  // Pending operator: none, or operator key code plus one
  typedef enum logic [2:0] {
    PEND_NONE = 3'd0,
    PEND_ADD  = 3'd1,
    PEND_SUB  = 3'd2,
    PEND_MUL  = 3'd3,
    PEND_DIV  = 3'd4,
    PEND_POW  = 3'd5
  } pend_e;

  typedef enum logic [2:0] {
    AF_PASS,
    AF_ADD,
    AF_SUB,
    AF_MUL,
    AF_DIV,
    AF_POW
  } alu_func_e;

  typedef enum logic [3:0] {
    AS_IDLE,
    AS_ADDSUB,
    AS_MUL,
    AS_ABS_A,
    AS_ABS_B,
    AS_DIV,
    AS_POW_SETUP,
    AS_POW_MUL,
    AS_NEG,
    AS_FIN
  } alu_state_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EVAL,
    CS_UPD_GO,
    CS_UPD_WAIT,
    CS_CALC_GO,
    CS_CALC_WAIT,
    CS_PUT
  } ctrl_state_e;

  // What a left-op-entry pass is for
  typedef enum logic [1:0] {
    CM_PREV,
    CM_PREV_DZ,
    CM_OPER,
    CM_EQU
  } calc_mode_e;

  typedef struct packed {
    logic      start;
    alu_func_e func;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

  function automatic alu_func_e pend_to_func(logic [2:0] pend);
    alu_func_e f;
    case (pend)
      PEND_ADD: f = AF_ADD;
      PEND_SUB: f = AF_SUB;
      PEND_MUL: f = AF_MUL;
      PEND_DIV: f = AF_DIV;
      PEND_POW: f = AF_POW;
      default:  f = AF_PASS;
    endcase
    return f;
  endfunction

endpackage

[design/kcc_key_if.sv]
// ----------------------------------------------------------------------------
// kcc_key_if
// Keypress channel: valid/ready handshake with key kind and key code.
// ----------------------------------------------------------------------------
interface kcc_key_if;
  logic                        valid;
  logic                        ready;
  logic [kcc_pkg::KIND_W-1:0]  op;
  logic [kcc_pkg::CODE_W-1:0]  key_code;

  modport source (output valid, output op, output key_code, input ready);
  modport sink   (input valid, input op, input key_code, output ready);
endinterface

[design/kcc_res_if.sv]
// ----------------------------------------------------------------------------
// kcc_res_if
// Result channel: valid/ready handshake with preview, entry and key status.
// ----------------------------------------------------------------------------
interface kcc_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [kcc_pkg::VAL_W-1:0]  preview_value;
  logic signed [kcc_pkg::VAL_W-1:0]  entry_value;
  logic                              error_shown;
  logic                              key_ignored;

  modport source (output valid, output preview_value, output entry_value,
                  output error_shown, output key_ignored, input ready);
  modport sink   (input valid, input preview_value, input entry_value,
                  input error_shown, input key_ignored, output ready);
endinterface

[design/kcc_alu.sv]
// ----------------------------------------------------------------------------
// kcc_alu
// Iterative arithmetic unit built around one shared adder: add, subtract,
// shift-add multiply, restoring divide and saturating power.
// ----------------------------------------------------------------------------
module kcc_alu #(
  parameter int WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcc_pkg::alu_req_t   req_i,
  input  logic [WIDTH-1:0]    a_i,
  input  logic [WIDTH-1:0]    b_i,
  input  logic [WIDTH-1:0]    addend_i,
  output kcc_pkg::alu_rsp_t   rsp_o,
  output logic [WIDTH-1:0]    result_o
);

  localparam int CntW = $clog2(WIDTH + 1);
  localparam logic [WIDTH-1:0] SignBit = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] One     = WIDTH'(1);
  localparam logic [WIDTH-1:0] WidthV  = WIDTH'(WIDTH);
  localparam logic [CntW-1:0]  CntFull = CntW'(WIDTH);
  localparam logic [CntW-1:0]  CntOne  = CntW'(1);

  kcc_pkg::alu_state_e state_q, state_d;
  kcc_pkg::alu_func_e  func_q;

  logic [WIDTH-1:0] acc_q, mcand_q, mplier_q, base_q, res_q;
  logic             big_q, rneg_q, dz_q;
  logic [CntW-1:0]  cnt_q;

  logic [WIDTH-1:0] add_x, add_y;
  logic             add_sub;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] rem_sh;
  logic             pow_ovf, pow_special, mplier_zero;

  assign sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
             + {{WIDTH{1'b0}}, add_sub};
  assign rem_sh      = {acc_q[WIDTH-2:0], mcand_q[WIDTH-1]};
  assign mplier_zero = (mplier_q == '0);
  // Product reaches the sign weight: saturate
  assign pow_ovf     = mplier_q[0] && (big_q || sum[WIDTH-1]);
  assign pow_special = mplier_q[WIDTH-1] || mplier_zero || (mcand_q == '0)
                     || (mcand_q == One);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kcc_pkg::AS_IDLE: begin
        if (req_i.start) begin
          case (req_i.func)
            kcc_pkg::AF_ADD, kcc_pkg::AF_SUB: state_d = kcc_pkg::AS_ADDSUB;
            kcc_pkg::AF_MUL:                  state_d = kcc_pkg::AS_MUL;
            kcc_pkg::AF_DIV: begin
              state_d = (b_i == '0) ? kcc_pkg::AS_FIN : kcc_pkg::AS_ABS_A;
            end
            kcc_pkg::AF_POW:                  state_d = kcc_pkg::AS_ABS_A;
            default:                          state_d = kcc_pkg::AS_FIN;
          endcase
        end
      end
      kcc_pkg::AS_ADDSUB: state_d = kcc_pkg::AS_FIN;
      kcc_pkg::AS_MUL: begin
        if (mplier_zero) state_d = kcc_pkg::AS_FIN;
      end
      kcc_pkg::AS_ABS_A: begin
        state_d = (func_q == kcc_pkg::AF_DIV) ? kcc_pkg::AS_ABS_B : kcc_pkg::AS_POW_SETUP;
      end
      kcc_pkg::AS_ABS_B: state_d = kcc_pkg::AS_DIV;
      kcc_pkg::AS_DIV: begin
        if (cnt_q == CntOne) state_d = kcc_pkg::AS_NEG;
      end
      kcc_pkg::AS_POW_SETUP: begin
        state_d = pow_special ? kcc_pkg::AS_FIN : kcc_pkg::AS_POW_MUL;
      end
      kcc_pkg::AS_POW_MUL: begin
        if (mplier_zero) begin
          if (cnt_q == CntOne) state_d = kcc_pkg::AS_NEG;
        end else if (pow_ovf) begin
          state_d = kcc_pkg::AS_FIN;
        end
      end
      kcc_pkg::AS_NEG: state_d = kcc_pkg::AS_FIN;
      kcc_pkg::AS_FIN: state_d = kcc_pkg::AS_IDLE;
      default:         state_d = kcc_pkg::AS_IDLE;
    endcase
  end

  // Adder operand selection and status
  always_comb begin
    add_x   = acc_q;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      kcc_pkg::AS_ADDSUB: begin
        add_x   = mcand_q;
        add_y   = mplier_q;
        add_sub = (func_q == kcc_pkg::AF_SUB);
      end
      kcc_pkg::AS_MUL, kcc_pkg::AS_POW_MUL: begin
        add_x = acc_q;
        add_y = mplier_q[0] ? mcand_q : '0;
      end
      kcc_pkg::AS_ABS_A: begin
        add_x   = '0;
        add_y   = mcand_q;
        add_sub = 1'b1;
      end
      kcc_pkg::AS_ABS_B: begin
        add_x   = '0;
        add_y   = mplier_q;
        add_sub = 1'b1;
      end
      kcc_pkg::AS_DIV: begin
        add_x   = rem_sh;
        add_y   = mplier_q;
        add_sub = 1'b1;
      end
      kcc_pkg::AS_NEG: begin
        add_x   = '0;
        add_y   = (func_q == kcc_pkg::AF_DIV) ? mcand_q : acc_q;
        add_sub = 1'b1;
      end
      default: begin
        add_x = acc_q;
      end
    endcase
  end

  assign rsp_o.done     = (state_q == kcc_pkg::AS_FIN);
  assign rsp_o.div_zero = dz_q;
  assign result_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcc_pkg::AS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      kcc_pkg::AS_IDLE: begin
        if (req_i.start) begin
          func_q   <= req_i.func;
          mcand_q  <= a_i;
          mplier_q <= b_i;
          acc_q    <= addend_i;
          big_q    <= 1'b0;
          cnt_q    <= CntFull;
          dz_q     <= (req_i.func == kcc_pkg::AF_DIV) && (b_i == '0);
          res_q    <= (req_i.func == kcc_pkg::AF_DIV) ? '0 : b_i;
          rneg_q   <= (req_i.func == kcc_pkg::AF_DIV) ? (a_i[WIDTH-1] ^ b_i[WIDTH-1])
                                                      : (a_i[WIDTH-1] & b_i[0]);
        end
      end
      kcc_pkg::AS_ADDSUB: res_q <= sum[WIDTH-1:0];
      kcc_pkg::AS_MUL: begin
        if (mplier_zero) begin
          res_q <= acc_q;
        end else begin
          acc_q    <= sum[WIDTH-1:0];
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      kcc_pkg::AS_ABS_A: begin
        if (mcand_q[WIDTH-1]) mcand_q <= sum[WIDTH-1:0];
      end
      kcc_pkg::AS_ABS_B: begin
        if (mplier_q[WIDTH-1]) mplier_q <= sum[WIDTH-1:0];
      end
      kcc_pkg::AS_DIV: begin
        // Restoring step: keep the difference when no borrow
        acc_q   <= sum[WIDTH] ? sum[WIDTH-1:0] : rem_sh;
        mcand_q <= {mcand_q[WIDTH-2:0], sum[WIDTH]};
        cnt_q   <= cnt_q - CntOne;
      end
      kcc_pkg::AS_POW_SETUP: begin
        if (mplier_q[WIDTH-1]) begin
          if (mcand_q == '0) begin
            res_q <= SignBit;
          end else if (mcand_q == One) begin
            res_q <= rneg_q ? '1 : One;
          end else begin
            res_q <= '0;
          end
        end else if (mplier_zero) begin
          res_q <= One;
        end else if (mcand_q == '0) begin
          res_q <= '0;
        end else if (mcand_q == One) begin
          res_q <= rneg_q ? '1 : One;
        end else begin
          // A base of two or more saturates within WIDTH rounds
          base_q   <= mcand_q;
          mcand_q  <= One;
          mplier_q <= mcand_q;
          acc_q    <= '0;
          big_q    <= 1'b0;
          cnt_q    <= (mplier_q < WidthV) ? CntW'(mplier_q) : CntFull;
        end
      end
      kcc_pkg::AS_POW_MUL: begin
        if (mplier_zero) begin
          if (cnt_q != CntOne) begin
            cnt_q    <= cnt_q - CntOne;
            mcand_q  <= acc_q;
            acc_q    <= '0;
            mplier_q <= base_q;
            big_q    <= 1'b0;
          end
        end else if (pow_ovf) begin
          res_q <= SignBit;
        end else begin
          acc_q    <= sum[WIDTH-1:0];
          mcand_q  <= mcand_q << 1;
          big_q    <= big_q | mcand_q[WIDTH-1] | mcand_q[WIDTH-2];
          mplier_q <= mplier_q >> 1;
        end
      end
      kcc_pkg::AS_NEG: begin
        if (rneg_q) begin
          res_q <= sum[WIDTH-1:0];
        end else begin
          res_q <= (func_q == kcc_pkg::AF_DIV) ? mcand_q : acc_q;
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

endmodule

[design/keypad_calculator_controller_core.sv]
// ----------------------------------------------------------------------------
// keypad_calculator_controller_core
// Keypress-driven integer calculator: a key sequencer around one shared
// iterative arithmetic unit, with a registered result stage.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake     Payload
//   key_i    in   valid/ready   op[2:0], key_code[3:0]
//   res_o    out  valid/ready   preview_value[31:0], entry_value[31:0],
//                               error_shown, key_ignored
//
// A key either goes straight to its result or makes up to two passes through
// the shared unit: add/sub, shift-add multiply, restoring divide or power.
// The single shared adder does one step per cycle.
// Reset clears all operands and flags at once; no sweep follows.
// A new key is taken while the previous result waits in the output register;
// its own result then holds until that register frees.
// ----------------------------------------------------------------------------
module keypad_calculator_controller_core #(
  parameter int WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kcc_key_if.sink      key_i,
  kcc_res_if.source    res_o
);

  localparam int OutW = kcc_pkg::VAL_W;
  localparam logic [WIDTH-1:0] DigitBase = WIDTH'(10);

  kcc_pkg::ctrl_state_e state_q, state_d;
  kcc_pkg::calc_mode_e  cmode_q;

  logic [kcc_pkg::KIND_W-1:0] kind_q;
  logic [kcc_pkg::CODE_W-1:0] code_q;
  logic [WIDTH-1:0]           left_q, entry_q, pv_q;
  logic [2:0]                 pend_q;
  logic                       op_pend_q, just_q, dz_q, ign_q, err_q;

  logic                       res_valid_q, res_valid_d;
  logic signed [OutW-1:0]     res_pv_q, res_entry_q;
  logic                       res_err_q, res_ign_q;

  kcc_pkg::alu_req_t alu_req;
  kcc_pkg::alu_rsp_t alu_rsp;
  logic [WIDTH-1:0]  alu_a, alu_b, alu_addend, alu_res;

  logic       key_accept, need_prev, entry_zero, code_bad, out_free;
  logic [2:0] pend_new;

  assign key_accept = key_i.valid && key_i.ready;
  assign need_prev  = op_pend_q && !just_q;
  assign entry_zero = (entry_q == '0);
  assign code_bad   = (code_q > kcc_pkg::OPER_CODE_MAX);
  assign out_free   = !res_valid_q || res_o.ready;
  assign pend_new   = code_q[2:0] + 3'd1;

  kcc_alu #(
    .WIDTH (WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .addend_i (alu_addend),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kcc_pkg::CS_IDLE: begin
        if (key_accept) state_d = kcc_pkg::CS_EVAL;
      end
      kcc_pkg::CS_EVAL: begin
        case (kind_q)
          kcc_pkg::KEY_DIGIT: state_d = kcc_pkg::CS_UPD_GO;
          kcc_pkg::KEY_OPER: begin
            if (code_bad) begin
              state_d = need_prev ? kcc_pkg::CS_CALC_GO : kcc_pkg::CS_PUT;
            end else begin
              state_d = need_prev ? kcc_pkg::CS_CALC_GO : kcc_pkg::CS_PUT;
            end
          end
          kcc_pkg::KEY_EQUALS: begin
            state_d = dz_q ? kcc_pkg::CS_PUT : kcc_pkg::CS_CALC_GO;
          end
          kcc_pkg::KEY_DELETE: begin
            if (entry_zero && !just_q) begin
              state_d = need_prev ? kcc_pkg::CS_CALC_GO : kcc_pkg::CS_PUT;
            end else if (just_q) begin
              state_d = kcc_pkg::CS_PUT;
            end else begin
              state_d = kcc_pkg::CS_UPD_GO;
            end
          end
          kcc_pkg::KEY_CLEAR: state_d = kcc_pkg::CS_PUT;
          default: state_d = need_prev ? kcc_pkg::CS_CALC_GO : kcc_pkg::CS_PUT;
        endcase
      end
      kcc_pkg::CS_UPD_GO: state_d = kcc_pkg::CS_UPD_WAIT;
      kcc_pkg::CS_UPD_WAIT: begin
        if (alu_rsp.done) state_d = need_prev ? kcc_pkg::CS_CALC_GO : kcc_pkg::CS_PUT;
      end
      kcc_pkg::CS_CALC_GO: state_d = kcc_pkg::CS_CALC_WAIT;
      kcc_pkg::CS_CALC_WAIT: begin
        if (alu_rsp.done) state_d = kcc_pkg::CS_PUT;
      end
      kcc_pkg::CS_PUT: begin
        if (out_free) state_d = kcc_pkg::CS_IDLE;
      end
      default: state_d = kcc_pkg::CS_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    key_i.ready   = (state_q == kcc_pkg::CS_IDLE);
    alu_req.start = (state_q == kcc_pkg::CS_UPD_GO) || (state_q == kcc_pkg::CS_CALC_GO);
    if (state_q == kcc_pkg::CS_UPD_GO) begin
      // Digit: entry*10 + code; delete: entry/10
      alu_req.func = (kind_q == kcc_pkg::KEY_DIGIT) ? kcc_pkg::AF_MUL : kcc_pkg::AF_DIV;
      alu_a        = entry_q;
      alu_b        = DigitBase;
      alu_addend   = (kind_q == kcc_pkg::KEY_DIGIT) ? WIDTH'(code_q) : '0;
    end else begin
      alu_req.func = kcc_pkg::pend_to_func(pend_q);
      alu_a        = left_q;
      alu_b        = entry_q;
      alu_addend   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcc_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Calculator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      entry_q   <= '0;
      pend_q    <= kcc_pkg::PEND_NONE;
      op_pend_q <= 1'b0;
      just_q    <= 1'b0;
      dz_q      <= 1'b0;
      kind_q    <= '0;
      code_q    <= '0;
      cmode_q   <= kcc_pkg::CM_PREV;
      pv_q      <= '0;
      ign_q     <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      case (state_q)
        kcc_pkg::CS_IDLE: begin
          if (key_accept) begin
            kind_q <= key_i.op;
            code_q <= key_i.key_code;
            ign_q  <= 1'b0;
            err_q  <= 1'b0;
          end
        end
        kcc_pkg::CS_EVAL: begin
          case (kind_q)
            kcc_pkg::KEY_DIGIT: begin
              dz_q   <= 1'b0;
              just_q <= 1'b0;
            end
            kcc_pkg::KEY_OPER: begin
              if (code_bad) begin
                ign_q   <= 1'b1;
                pv_q    <= entry_q;
                cmode_q <= kcc_pkg::CM_PREV;
              end else begin
                dz_q <= 1'b0;
                if (!op_pend_q) begin
                  left_q    <= entry_q;
                  entry_q   <= '0;
                  pend_q    <= pend_new;
                  op_pend_q <= 1'b1;
                  just_q    <= 1'b1;
                  pv_q      <= '0;
                end else if (just_q) begin
                  // Second operator in a row: drop it
                  ign_q <= 1'b1;
                  pv_q  <= entry_q;
                end else begin
                  cmode_q <= kcc_pkg::CM_OPER;
                end
              end
            end
            kcc_pkg::KEY_EQUALS: begin
              if (dz_q) begin
                left_q    <= '0;
                entry_q   <= '0;
                op_pend_q <= 1'b0;
                just_q    <= 1'b0;
                dz_q      <= 1'b0;
                err_q     <= 1'b1;
                pv_q      <= '0;
              end else begin
                cmode_q <= kcc_pkg::CM_EQU;
              end
            end
            kcc_pkg::KEY_DELETE: begin
              if (entry_zero && !just_q) begin
                ign_q   <= 1'b1;
                pv_q    <= entry_q;
                cmode_q <= kcc_pkg::CM_PREV;
              end else if (just_q) begin
                // Undo the operator: restore the left operand
                entry_q   <= left_q;
                op_pend_q <= 1'b0;
                just_q    <= 1'b0;
                pv_q      <= left_q;
              end
            end
            kcc_pkg::KEY_CLEAR: begin
              left_q    <= '0;
              entry_q   <= '0;
              op_pend_q <= 1'b0;
              just_q    <= 1'b0;
              dz_q      <= 1'b0;
              pv_q      <= '0;
            end
            default: begin
              ign_q   <= 1'b1;
              pv_q    <= entry_q;
              cmode_q <= kcc_pkg::CM_PREV;
            end
          endcase
        end
        kcc_pkg::CS_UPD_WAIT: begin
          if (alu_rsp.done) begin
            entry_q <= alu_res;
            pv_q    <= alu_res;
            cmode_q <= kcc_pkg::CM_PREV_DZ;
          end
        end
        kcc_pkg::CS_CALC_WAIT: begin
          if (alu_rsp.done) begin
            case (cmode_q)
              kcc_pkg::CM_PREV: pv_q <= alu_res;
              kcc_pkg::CM_PREV_DZ: begin
                pv_q <= alu_res;
                if (alu_rsp.div_zero) dz_q <= 1'b1;
              end
              kcc_pkg::CM_OPER: begin
                left_q    <= alu_res;
                entry_q   <= '0;
                pend_q    <= pend_new;
                op_pend_q <= 1'b1;
                just_q    <= 1'b1;
                dz_q      <= alu_rsp.div_zero;
                pv_q      <= '0;
              end
              kcc_pkg::CM_EQU: begin
                pv_q      <= need_prev ? alu_res : entry_q;
                entry_q   <= alu_res;
                op_pend_q <= 1'b0;
                just_q    <= 1'b0;
                dz_q      <= alu_rsp.div_zero;
              end
              default: pv_q <= alu_res;
            endcase
          end
        end
        default: begin
          pv_q <= pv_q;
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    res_valid_d = res_valid_q;
    if ((state_q == kcc_pkg::CS_PUT) && out_free) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == kcc_pkg::CS_PUT) && out_free) begin
      res_pv_q    <= OutW'($signed(pv_q));
      res_entry_q <= OutW'($signed(entry_q));
      res_err_q   <= err_q;
      res_ign_q   <= ign_q;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.preview_value = res_pv_q;
  assign res_o.entry_value   = res_entry_q;
  assign res_o.error_shown   = res_err_q;
  assign res_o.key_ignored   = res_ign_q;

  // An operator just pressed is always a pending one
  a_just_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    just_q |-> op_pend_q)
    else $error("operator marked just pressed without a pending operator");

  a_alu_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == kcc_pkg::CS_UPD_WAIT || state_q == kcc_pkg::CS_CALC_WAIT))
    else $error("arithmetic unit finished while the sequencer was not waiting");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.error_shown) |->
      (res_o.preview_value == '0 && res_o.entry_value == '0 && !res_o.key_ignored))
    else $error("error transaction carries nonzero values or an ignored key");

  a_put_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kcc_pkg::CS_PUT && out_free) |=> res_o.valid)
    else $error("finished key produced no result transaction");

endmodule

[verif/tb_keypad_calculator_controller_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_calculator_controller_core
// Self-checking bench for the keypad calculator: a directed key sequence and
// random key expressions are sent with bursty valid, the receiver stalls on a
// pattern of its own, and every result is compared with a 32-bit model of the
// calculator state kept in the bench.
// ----------------------------------------------------------------------------
module tb_keypad_calculator_controller_core;

  localparam int W             = 32;
  localparam int HALF_PERIOD   = 5;
  localparam int RANDOM_KEYS   = 680;
  localparam int SETTLE_CYCLES = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLDOFF_AFTER = 300;
  localparam int HOLDOFF_LEN   = 600;

  // Operator key codes
  localparam logic [kcc_pkg::CODE_W-1:0] OPK_ADD = 4'd0;
  localparam logic [kcc_pkg::CODE_W-1:0] OPK_SUB = 4'd1;
  localparam logic [kcc_pkg::CODE_W-1:0] OPK_MUL = 4'd2;
  localparam logic [kcc_pkg::CODE_W-1:0] OPK_DIV = 4'd3;
  localparam logic [kcc_pkg::CODE_W-1:0] OPK_POW = 4'd4;
  localparam logic [kcc_pkg::CODE_W-1:0] OPK_BAD = 4'd15;

  // Key kinds with no meaning
  localparam logic [kcc_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [kcc_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef logic [W-1:0] word_t;
  localparam word_t MOST_NEG = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                       wait_idle;
    logic [kcc_pkg::KIND_W-1:0] kind;
    logic [kcc_pkg::CODE_W-1:0] code;
  } keypress_t;

  typedef struct packed {
    logic signed [kcc_pkg::VAL_W-1:0] preview;
    logic signed [kcc_pkg::VAL_W-1:0] entry;
    logic                             err;
    logic                             ign;
  } key_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       drv_valid = 1'b0;
  logic [kcc_pkg::KIND_W-1:0] drv_kind  = '0;
  logic [kcc_pkg::CODE_W-1:0] drv_code  = '0;
  logic                       rcv_ready = 1'b0;

  kcc_key_if key_bus ();
  kcc_res_if res_bus ();

  assign key_bus.valid    = drv_valid;
  assign key_bus.op       = drv_kind;
  assign key_bus.key_code = drv_code;
  assign res_bus.ready    = rcv_ready;

  keypad_calculator_controller_core #(.WIDTH(W)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_bus),
    .res_o  (res_bus)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  keypress_t   key_q[$];
  key_result_t result_q[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned key_count    = 0;
  logic        settle_next  = 1'b0;

  // Calculator state as the bench sees it
  word_t          calc_left;
  word_t          calc_entry;
  kcc_pkg::pend_e calc_pend;
  logic           op_pending;
  logic           op_fresh;
  logic           dz_seen;

  function automatic word_t abs_w(word_t v);
    return v[W-1] ? -v : v;
  endfunction

  function automatic word_t quot_trunc(word_t a, word_t b);
    word_t q;
    q = abs_w(a) / abs_w(b);
    return (a[W-1] ^ b[W-1]) ? -q : q;
  endfunction

  // Integer power, saturating to the most negative value when out of range
  function automatic word_t power_trunc(word_t base, word_t ex);
    logic [63:0] mag;
    logic [63:0] am;
    logic        neg_res;
    word_t       m;
    int unsigned n;
    am      = 64'(abs_w(base));
    neg_res = base[W-1] && ex[0];
    if (ex[W-1]) begin
      if (am == 0) return MOST_NEG;
      if (am == 1) return neg_res ? '1 : word_t'(1);
      return '0;
    end
    if (ex == 0) return word_t'(1);
    if (am == 0) return '0;
    if (am == 1) return neg_res ? '1 : word_t'(1);
    mag = 64'd1;
    for (n = 0; n < ex; n++) begin
      if (mag > 64'(MOST_NEG) / am) return MOST_NEG;
      mag = mag * am;
    end
    if (mag >= 64'(MOST_NEG)) return MOST_NEG;
    m = mag[W-1:0];
    return neg_res ? -m : m;
  endfunction

  function automatic word_t apply_op(word_t a, word_t b, kcc_pkg::pend_e sel,
                                     output logic dz);
    dz = 1'b0;
    case (sel)
      kcc_pkg::PEND_ADD: return a + b;
      kcc_pkg::PEND_SUB: return a - b;
      kcc_pkg::PEND_MUL: return a * b;
      kcc_pkg::PEND_DIV: begin
        if (b == 0) begin
          dz = 1'b1;
          return '0;
        end
        return quot_trunc(a, b);
      end
      kcc_pkg::PEND_POW: return power_trunc(a, b);
      default:  return b;
    endcase
  endfunction

  function automatic word_t live_value(output logic dz);
    dz = 1'b0;
    if (op_fresh || !op_pending) return calc_entry;
    return apply_op(calc_left, calc_entry, calc_pend, dz);
  endfunction

  task automatic clear_calc();
    calc_left  = '0;
    calc_entry = '0;
    op_pending = 1'b0;
    op_fresh   = 1'b0;
    dz_seen    = 1'b0;
  endtask

  // Advance the calculator by one key and queue the result it must produce
  task automatic predict_key(logic [kcc_pkg::KIND_W-1:0] kind,
                             logic [kcc_pkg::CODE_W-1:0] code);
    key_result_t r;
    word_t       pv;
    logic        dz;
    r  = '0;
    pv = '0;
    case (kind)
      kcc_pkg::KEY_DIGIT: begin
        dz_seen    = 1'b0;
        calc_entry = calc_entry * 10 + word_t'(code);
        op_fresh   = 1'b0;
        pv         = live_value(dz);
        dz_seen    = dz_seen | dz;
      end
      kcc_pkg::KEY_OPER: begin
        if (code > kcc_pkg::OPER_CODE_MAX) begin
          r.ign = 1'b1;
          pv    = live_value(dz);
        end else begin
          dz_seen = 1'b0;
          if (op_pending && op_fresh) begin
            r.ign = 1'b1;
            pv    = calc_entry;
          end else begin
            if (!op_pending) begin
              calc_left = calc_entry;
            end else begin
              calc_left = apply_op(calc_left, calc_entry, calc_pend, dz);
              dz_seen   = dz_seen | dz;
            end
            calc_entry = '0;
            calc_pend  = kcc_pkg::pend_e'(3'(code) + 3'd1);
            op_pending = 1'b1;
            op_fresh   = 1'b1;
            pv         = calc_entry;
          end
        end
      end
      kcc_pkg::KEY_EQUALS: begin
        if (dz_seen) begin
          clear_calc();
          r.err = 1'b1;
        end else begin
          pv         = live_value(dz);
          dz_seen    = dz_seen | dz;
          calc_entry = apply_op(calc_left, calc_entry, calc_pend, dz);
          dz_seen    = dz_seen | dz;
          op_pending = 1'b0;
          op_fresh   = 1'b0;
        end
      end
      kcc_pkg::KEY_DELETE: begin
        if (calc_entry == 0 && !op_fresh) begin
          r.ign = 1'b1;
          pv    = live_value(dz);
        end else begin
          if (op_fresh) begin
            // Undo the operator: take the left operand back
            calc_entry = calc_left;
            op_pending = 1'b0;
            op_fresh   = 1'b0;
          end else begin
            calc_entry = quot_trunc(calc_entry, word_t'(10));
          end
          pv      = live_value(dz);
          dz_seen = dz_seen | dz;
        end
      end
      kcc_pkg::KEY_CLEAR: begin
        clear_calc();
      end
      default: begin
        r.ign = 1'b1;
        pv    = live_value(dz);
      end
    endcase
    r.preview = pv;
    r.entry   = calc_entry;
    result_q.push_back(r);
  endtask

  task automatic push_key(logic [kcc_pkg::KIND_W-1:0] kind,
                          logic [kcc_pkg::CODE_W-1:0] code);
    keypress_t k;
    k.wait_idle = settle_next;
    k.kind      = kind;
    k.code      = code;
    settle_next = 1'b0;
    key_q.push_back(k);
    if (kind <= kcc_pkg::KEY_CLEAR) key_count++;
  endtask

  task automatic push_number(int unsigned max_digits);
    repeat ($urandom_range(1, max_digits)) begin
      if ($urandom_range(0, 15) == 0)
        push_key(kcc_pkg::KEY_DIGIT, 4'($urandom_range(10, 15)));
      else
        push_key(kcc_pkg::KEY_DIGIT, 4'($urandom_range(0, 9)));
    end
  endtask

  // One well-formed expression with random content and the odd stray key
  task automatic push_expression();
    int unsigned                len;
    logic [kcc_pkg::CODE_W-1:0] opc;
    len = ($urandom_range(0, 7) == 0) ? 11 : 3;
    push_number(len);
    repeat ($urandom_range(1, 3)) begin
      opc = 4'($urandom_range(0, 4));
      push_key(kcc_pkg::KEY_OPER, opc);
      if ($urandom_range(0, 7) == 0)
        push_key(kcc_pkg::KEY_OPER, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 9) == 0)
        push_key(kcc_pkg::KEY_DELETE, 4'($urandom_range(0, 15)));
      push_number(opc == OPK_POW ? 1 : len);
      if ($urandom_range(0, 7) == 0)
        push_key(kcc_pkg::KEY_DELETE, 4'($urandom_range(0, 15)));
    end
    push_key(kcc_pkg::KEY_EQUALS, 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 5) == 0)
      push_key(kcc_pkg::KEY_EQUALS, 4'($urandom_range(0, 15)));
    if ($urandom_range(0, 4) == 0)
      push_key(kcc_pkg::KEY_CLEAR, 4'($urandom_range(0, 15)));
  endtask

  // Sender: bursts of transactions separated by random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    keypress_t nxt;
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      drv_kind   <= '0;
      drv_code   <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!drv_valid || key_bus.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (key_q.size() == 0 ||
                   (key_q[0].wait_idle && (drv_valid || result_q.size() != 0))) begin
        // hold until every outstanding result has been returned
        drv_valid <= 1'b0;
      end else begin
        nxt = key_q.pop_front();
        drv_valid <= 1'b1;
        drv_kind  <= nxt.kind;
        drv_code  <= nxt.code;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          case ($urandom_range(0, 7))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(40, 90);
            default: gap_left = $urandom_range(1, 20);
          endcase
        end
      end
    end
  end

  // Receiver: stall pattern switches now and then, plus one long hold-off
  rx_mode_e    rx_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  logic        hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLDOFF_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLDOFF_LEN;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 128);
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   rcv_ready <= 1'b1;
          RX_COIN:   rcv_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rcv_ready <= ($urandom_range(0, 3) == 0);
          default:   rcv_ready <= ~rcv_ready;
        endcase
      end
    end
  end

  // Monitor: check the returned transaction first, then predict the accepted key
  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni) begin
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: preview %0d entry %0d err %0b ign %0b",
                     res_bus.preview_value, res_bus.entry_value,
                     res_bus.error_shown, res_bus.key_ignored);
        end else begin
          want = result_q.pop_front();
          if (res_bus.preview_value !== want.preview || res_bus.entry_value !== want.entry ||
              res_bus.error_shown !== want.err || res_bus.key_ignored !== want.ign) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected preview %0d entry %0d err %0b ign %0b, %s",
                       results_seen, want.preview, want.entry, want.err, want.ign,
                       $sformatf("got preview %0d entry %0d err %0b ign %0b",
                                 res_bus.preview_value, res_bus.entry_value,
                                 res_bus.error_shown, res_bus.key_ignored));
          end
        end
      end
      if (key_bus.valid && key_bus.ready) predict_key(key_bus.op, key_bus.key_code);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((key_bus.valid && key_bus.ready) || (res_bus.valid && res_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_keypad_calculator_controller_core NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic paused_mid;
    paused_mid = 1'b0;
    calc_pend  = kcc_pkg::PEND_NONE;
    clear_calc();

    push_key(kcc_pkg::KEY_EQUALS, 4'd0);        // no operator chosen yet
    push_key(kcc_pkg::KEY_DELETE, 4'd0);        // nothing to remove
    push_key(kcc_pkg::KEY_DIGIT, 4'd0);
    push_key(kcc_pkg::KEY_DIGIT, 4'd9);
    push_key(kcc_pkg::KEY_DIGIT, 4'd15);        // out-of-range digit code
    push_key(kcc_pkg::KEY_DELETE, 4'd0);
    push_key(kcc_pkg::KEY_OPER, OPK_ADD);
    push_key(kcc_pkg::KEY_OPER, OPK_MUL);       // second operator in a row
    push_key(kcc_pkg::KEY_DELETE, 4'd0);        // restore the left operand
    push_key(kcc_pkg::KEY_OPER, OPK_SUB);
    push_key(kcc_pkg::KEY_DIGIT, 4'd12);
    push_key(kcc_pkg::KEY_EQUALS, 4'd0);
    push_key(kcc_pkg::KEY_OPER, OPK_POW);
    push_key(kcc_pkg::KEY_DIGIT, 4'd3);
    push_key(kcc_pkg::KEY_EQUALS, 4'd0);
    push_key(kcc_pkg::KEY_EQUALS, 4'd0);        // repeat with a negative exponent
    push_key(kcc_pkg::KEY_DIGIT, 4'd7);
    push_key(kcc_pkg::KEY_OPER, OPK_DIV);
    push_key(kcc_pkg::KEY_DIGIT, 4'd0);         // divide by zero in the preview
    push_key(kcc_pkg::KEY_EQUALS, 4'd0);        // error and clear
    push_key(kcc_pkg::KEY_OPER, OPK_BAD);
    push_key(KIND_SPARE_HI, 4'd8);
    push_key(KIND_SPARE_LO, 4'd3);
    push_key(kcc_pkg::KEY_DIGIT, 4'd4);
    push_key(kcc_pkg::KEY_CLEAR, 4'd0);

    settle_next = 1'b1;
    key_count   = 0;
    while (key_count < RANDOM_KEYS) begin
      if (!paused_mid && key_count >= 450) begin
        settle_next = 1'b1;
        paused_mid  = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) push_expression();
      else push_key(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (key_q.size() != 0 || drv_valid || result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && result_q.size() == 0) begin
      $display("tb_keypad_calculator_controller_core OK");
    end else begin
      $display("tb_keypad_calculator_controller_core NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
design/kcc_pkg.sv
design/kcc_key_if.sv
design/kcc_res_if.sv
design/kcc_alu.sv
design/keypad_calculator_controller_core.sv
verif/tb_keypad_calculator_controller_core.sv
